FILE: sv/tfcm_pkg.sv
// shared types and constants for the thermal false-color map
// pixel transfer structs, luma weights, segment breakpoints and ramp tables
// no dependencies
package tfcm_pkg;

  // input pixel transfer
  typedef struct packed {
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
    logic [7:0] alpha_in;
    logic       frame_end_in;
  } tfcm_in_t;

  // output pixel transfer
  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic [7:0] alpha_out;
    logic       frame_end_out;
  } tfcm_out_t;

  // luma weights, sum of weights is 256
  localparam logic [5:0] LumaWeightR = 6'd54;
  localparam logic [7:0] LumaWeightG = 8'd183;
  localparam logic [4:0] LumaWeightB = 5'd19;

  // segment breakpoints on the 8-bit brightness
  localparam logic [7:0] BreakCyan   = 8'd43;
  localparam logic [7:0] BreakGreen  = 8'd85;
  localparam logic [7:0] BreakYellow = 8'd128;
  localparam logic [7:0] BreakRed    = 8'd170;
  localparam logic [7:0] BreakWhite  = 8'd213;

  // ramp divisors and full scale
  localparam int unsigned RampDivLong  = 43;
  localparam int unsigned RampDivShort = 42;
  localparam int unsigned FullScale    = 255;
  localparam logic [7:0]  ChanMax      = 8'd255;

  // ramp offset stays within 0..42 in every segment
  localparam int unsigned RampDepth = 43;
  localparam int unsigned RampIdxW  = $clog2(RampDepth);

  typedef logic [7:0] ramp_lut_t [RampDepth];

  // (t*255)/43 for every offset, built at elaboration
  function automatic ramp_lut_t build_ramp_long();
    ramp_lut_t lut;
    for (int unsigned i = 0; i < RampDepth; i++) begin
      lut[i] = 8'((i * FullScale) / RampDivLong);
    end
    return lut;
  endfunction

  // (t*255)/42 for every offset; offset 42 gives 255
  function automatic ramp_lut_t build_ramp_short();
    ramp_lut_t lut;
    for (int unsigned i = 0; i < RampDepth; i++) begin
      lut[i] = 8'((i * FullScale) / RampDivShort);
    end
    return lut;
  endfunction

  localparam ramp_lut_t RampLong  = build_ramp_long();
  localparam ramp_lut_t RampShort = build_ramp_short();

endpackage

FILE: sv/thermal_false_color_map.sv
// thermal false-color map, top level: luma, segment decode, ramp lookup
// depends on tfcm_pkg
//
//  channel | direction | handshake              | payload
//  in      | sink      | in_valid_i / in_ready_o   | in_data_i  (tfcm_in_t)
//  out     | source    | out_valid_o / out_ready_i | out_data_o (tfcm_out_t)
//
// four register stages: weighted products, brightness sum, segment decode,
// ramp table lookup into the output register.
// one pixel is accepted every cycle while the output side takes transfers.
// each stage carries its own valid bit and fills any bubble ahead of it,
// so a stall at the output holds every stage without loss or repeat.
// reset clears only the valid bits; the data path needs none.
module thermal_false_color_map
  import tfcm_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  tfcm_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output tfcm_out_t out_data_o
);

  typedef enum logic [2:0] {
    SegBlue,
    SegCyan,
    SegGreen,
    SegYellow,
    SegRed,
    SegWhite
  } seg_e;

  // stage valid bits
  logic s1_v_q, s2_v_q, s3_v_q, s4_v_q;
  logic s1_ready, s2_ready, s3_ready, s4_ready;

  // stage 1: weighted products
  logic [13:0] prod_r_q, prod_r_d;
  logic [15:0] prod_g_q, prod_g_d;
  logic [12:0] prod_b_q, prod_b_d;
  logic [7:0]  s1_alpha_q;
  logic        s1_fe_q;

  // stage 2: brightness
  logic [15:0] luma_sum;
  logic [7:0]  luma_q, luma_d;
  logic [7:0]  s2_alpha_q;
  logic        s2_fe_q;

  // stage 3: segment and offset
  seg_e                seg_q, seg_d;
  logic [7:0]          offs_full;
  logic [RampIdxW-1:0] offs_q, offs_d;
  logic [7:0]          s3_alpha_q;
  logic                s3_fe_q;

  // stage 4: output register
  tfcm_out_t   out_q, out_d;
  logic [7:0]  ramp_long, ramp_short;

  // stage advance: a stage loads when it is empty or its successor moves
  assign s4_ready   = !s4_v_q || out_ready_i;
  assign s3_ready   = !s3_v_q || s4_ready;
  assign s2_ready   = !s2_v_q || s3_ready;
  assign s1_ready   = !s1_v_q || s2_ready;
  assign in_ready_o = s1_ready;

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
      s4_v_q <= 1'b0;
    end else begin
      if (s1_ready) s1_v_q <= in_valid_i;
      if (s2_ready) s2_v_q <= s1_v_q;
      if (s3_ready) s3_v_q <= s2_v_q;
      if (s4_ready) s4_v_q <= s3_v_q;
    end
  end

  // luma products, constant multipliers
  always_comb begin
    prod_r_d = 14'(in_data_i.red_in)   * 14'(LumaWeightR);
    prod_g_d = 16'(in_data_i.green_in) * 16'(LumaWeightG);
    prod_b_d = 13'(in_data_i.blue_in)  * 13'(LumaWeightB);
  end

  // brightness is the weighted sum divided by 256
  assign luma_sum = 16'(prod_r_q) + prod_g_q + 16'(prod_b_q);
  assign luma_d   = luma_sum[15:8];

  // segment decode and offset from the segment start
  always_comb begin
    if (luma_q < BreakCyan) begin
      seg_d     = SegBlue;
      offs_full = luma_q;
    end else if (luma_q < BreakGreen) begin
      seg_d     = SegCyan;
      offs_full = luma_q - BreakCyan;
    end else if (luma_q < BreakYellow) begin
      seg_d     = SegGreen;
      offs_full = luma_q - BreakGreen;
    end else if (luma_q < BreakRed) begin
      seg_d     = SegYellow;
      offs_full = luma_q - BreakYellow;
    end else if (luma_q < BreakWhite) begin
      seg_d     = SegRed;
      offs_full = luma_q - BreakRed;
    end else begin
      seg_d     = SegWhite;
      offs_full = luma_q - BreakWhite;
    end
    offs_d = offs_full[RampIdxW-1:0];
  end

  // ramp lookup and color assembly
  assign ramp_long  = RampLong[offs_q];
  assign ramp_short = RampShort[offs_q];

  always_comb begin
    out_d.alpha_out     = s3_alpha_q;
    out_d.frame_end_out = s3_fe_q;
    unique case (seg_q)
      SegBlue: begin
        out_d.red_out   = '0;
        out_d.green_out = '0;
        out_d.blue_out  = ramp_long;
      end
      SegCyan: begin
        out_d.red_out   = '0;
        out_d.green_out = ramp_short;
        out_d.blue_out  = ChanMax;
      end
      SegGreen: begin
        out_d.red_out   = '0;
        out_d.green_out = ChanMax;
        out_d.blue_out  = ChanMax - ramp_long;
      end
      SegYellow: begin
        out_d.red_out   = ramp_short;
        out_d.green_out = ChanMax;
        out_d.blue_out  = '0;
      end
      SegRed: begin
        out_d.red_out   = ChanMax;
        out_d.green_out = ChanMax - ramp_long;
        out_d.blue_out  = '0;
      end
      SegWhite: begin
        out_d.red_out   = ChanMax;
        out_d.green_out = ramp_short;
        out_d.blue_out  = ramp_short;
      end
      default: begin
        out_d.red_out   = '0;
        out_d.green_out = '0;
        out_d.blue_out  = '0;
      end
    endcase
  end

  // data path registers, no reset
  always_ff @(posedge clk_i) begin
    if (s1_ready) begin
      prod_r_q   <= prod_r_d;
      prod_g_q   <= prod_g_d;
      prod_b_q   <= prod_b_d;
      s1_alpha_q <= in_data_i.alpha_in;
      s1_fe_q    <= in_data_i.frame_end_in;
    end
    if (s2_ready) begin
      luma_q     <= luma_d;
      s2_alpha_q <= s1_alpha_q;
      s2_fe_q    <= s1_fe_q;
    end
    if (s3_ready) begin
      seg_q      <= seg_d;
      offs_q     <= offs_d;
      s3_alpha_q <= s2_alpha_q;
      s3_fe_q    <= s2_fe_q;
    end
    if (s4_ready) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = s4_v_q;
  assign out_data_o  = out_q;

endmodule

FILE: sv/tfcm_checker.sv
// port-level checks for the thermal false-color map, bound to the top level
// depends on tfcm_pkg
module tfcm_checker
  import tfcm_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_o,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input tfcm_out_t out_data_o
);

  // no output transfer offered once reset has been seen at a clock edge
  assert property (@(posedge clk_i) !rst_ni |=> !out_valid_o)
    else $error("output valid during reset");

  // a stalled output transfer holds its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled output transfer changed");

  // the input side only backs up behind a stalled output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input not ready without output stall");

  // nonzero red belongs to the yellow, red or white segments
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.red_out != 8'd0 |->
      out_data_o.blue_out == 8'd0 ||
      (out_data_o.red_out == ChanMax && out_data_o.green_out == out_data_o.blue_out))
    else $error("red channel outside its segments");

  // zero red belongs to the blue, cyan or green segments, or to the first yellow level
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.red_out == 8'd0 |->
      out_data_o.green_out == 8'd0 || out_data_o.blue_out == ChanMax ||
      out_data_o.green_out == ChanMax)
    else $error("cool colors outside their segments");

endmodule

bind thermal_false_color_map tfcm_checker u_tfcm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

FILE: sim/thermal_map_monitor.sv
// pixel stream monitor for the thermal false-color map: predicts and compares
// depends on tfcm_pkg for the transfer structs
module thermal_map_monitor
  import tfcm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  tfcm_in_t    in_data_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  tfcm_out_t   out_data_i,
  output int unsigned error_count_o,
  output int unsigned pending_o
);

  // segment starts on the brightness scale
  localparam int unsigned KneeCyan   = 43;
  localparam int unsigned KneeGreen  = 85;
  localparam int unsigned KneeYellow = 128;
  localparam int unsigned KneeRed    = 170;
  localparam int unsigned KneeWhite  = 213;
  localparam int unsigned SpanLong   = 43;
  localparam int unsigned SpanShort  = 42;
  localparam logic [7:0]  Full       = 8'd255;

  // false-color pixels still owed by the block, oldest first
  tfcm_out_t expected_pixels[$];

  initial begin
    error_count_o = 0;
    pending_o     = 0;
  end

  // linear ramp over one segment, truncated
  function automatic logic [7:0] ramp_of(input int unsigned offset, input int unsigned span);
    return 8'((offset * 255) / span);
  endfunction

  // brightness, then the six-segment color map
  function automatic tfcm_out_t false_color_of(input tfcm_in_t px);
    tfcm_out_t   fc;
    int unsigned luma;
    luma = (54 * int'(px.red_in) + 183 * int'(px.green_in) + 19 * int'(px.blue_in)) >> 8;
    fc.alpha_out     = px.alpha_in;
    fc.frame_end_out = px.frame_end_in;
    if (luma < KneeCyan) begin
      fc.red_out   = '0;
      fc.green_out = '0;
      fc.blue_out  = ramp_of(luma, SpanLong);
    end else if (luma < KneeGreen) begin
      fc.red_out   = '0;
      fc.green_out = ramp_of(luma - KneeCyan, SpanShort);
      fc.blue_out  = Full;
    end else if (luma < KneeYellow) begin
      fc.red_out   = '0;
      fc.green_out = Full;
      fc.blue_out  = Full - ramp_of(luma - KneeGreen, SpanLong);
    end else if (luma < KneeRed) begin
      fc.red_out   = ramp_of(luma - KneeYellow, SpanShort);
      fc.green_out = Full;
      fc.blue_out  = '0;
    end else if (luma < KneeWhite) begin
      fc.red_out   = Full;
      fc.green_out = Full - ramp_of(luma - KneeRed, SpanLong);
      fc.blue_out  = '0;
    end else begin
      fc.red_out   = Full;
      fc.green_out = ramp_of(luma - KneeWhite, SpanShort);
      fc.blue_out  = fc.green_out;
    end
    return fc;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    error_count_o++;
  endtask

  // compare each output transfer, then queue the prediction for each input transfer
  always @(posedge clk_i) begin : watch
    tfcm_out_t want;
    if (rst_ni) begin
      if (out_valid_i && out_ready_i) begin
        if (expected_pixels.size() == 0) begin
          report_mismatch($sformatf("output transfer %0h with nothing pending", out_data_i));
        end else begin
          want = expected_pixels.pop_front();
          if (out_data_i.red_out !== want.red_out)
            report_mismatch($sformatf("red %0d, want %0d", out_data_i.red_out, want.red_out));
          if (out_data_i.green_out !== want.green_out)
            report_mismatch($sformatf("green %0d, want %0d", out_data_i.green_out,
                                      want.green_out));
          if (out_data_i.blue_out !== want.blue_out)
            report_mismatch($sformatf("blue %0d, want %0d", out_data_i.blue_out, want.blue_out));
          if (out_data_i.alpha_out !== want.alpha_out)
            report_mismatch($sformatf("alpha %0d, want %0d", out_data_i.alpha_out,
                                      want.alpha_out));
          if (out_data_i.frame_end_out !== want.frame_end_out)
            report_mismatch($sformatf("frame end %0b, want %0b", out_data_i.frame_end_out,
                                      want.frame_end_out));
        end
      end
      if (in_valid_i && in_ready_i) begin
        expected_pixels.push_back(false_color_of(in_data_i));
      end
      pending_o <= expected_pixels.size();
    end
  end

endmodule

FILE: sim/testbench.sv
// top of the thermal false-color map test: clock, reset, pixel stimulus, verdict
// depends on tfcm_pkg, thermal_false_color_map and thermal_map_monitor
module testbench;
  import tfcm_pkg::*;

  localparam int unsigned RandomPixels = 1800;
  localparam int unsigned HoldCycles   = 300;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  tfcm_in_t    in_data_i;
  logic        out_valid_o;
  logic        out_ready_i;
  tfcm_out_t   out_data_o;
  int unsigned error_count;
  int unsigned pending;

  // receiver long hold-off request and sender burst control
  bit          hold_req;
  int unsigned burst_left;

  thermal_false_color_map dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  thermal_map_monitor monitor (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_i    (in_ready_o),
    .in_data_i     (in_data_i),
    .out_valid_i   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_data_i    (out_data_o),
    .error_count_o (error_count),
    .pending_o     (pending)
  );

  // clock
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // run limit
  initial begin
    #5000000;
    $display("FAILED: results differ");
    $finish;
  end

  function automatic tfcm_in_t pixel_of(input logic [7:0] r, input logic [7:0] g,
                                        input logic [7:0] b, input logic [7:0] a,
                                        input logic fe);
    tfcm_in_t px;
    px.red_in       = r;
    px.green_in     = g;
    px.blue_in      = b;
    px.alpha_in     = a;
    px.frame_end_in = fe;
    return px;
  endfunction

  // random pixel: mostly uniform, some gray near a segment boundary
  function automatic tfcm_in_t random_pixel();
    int unsigned knees[5] = '{43, 85, 128, 170, 213};
    int          v;
    logic        fe;
    fe = ($urandom_range(0, 15) == 0);
    if ($urandom_range(0, 3) != 0) begin
      return pixel_of(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), fe);
    end
    v = int'(knees[$urandom_range(0, 4)]) + int'($urandom_range(0, 3)) - 2;
    return pixel_of(8'(v), 8'(v), 8'(v), 8'($urandom), fe);
  endfunction

  function automatic int unsigned draw_wait(input bit calm);
    if (calm) return 0;
    return $urandom_range(0, 19);
  endfunction

  // offer one pixel and wait for its transfer
  task automatic send_pixel(input tfcm_in_t px, input bit calm);
    int unsigned gap;
    gap = draw_wait(calm);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= px;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // stop offering and wait until every predicted pixel has come out
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  // receiver: random stalls, calm stretches, one long hold-off on request
  initial begin : receiver
    int unsigned stall;
    bit          calm;
    out_ready_i = 1'b0;
    calm        = 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if ($urandom_range(0, 63) == 0) calm = ~calm;
      stall = draw_wait(calm);
      if (hold_req) begin
        hold_req = 1'b0;
        stall    = HoldCycles;
      end
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // reset, directed pixels, random pixels, verdict
  initial begin : stimulus
    tfcm_in_t    directed[$];
    bit          calm;
    in_valid_i = 1'b0;
    in_data_i  = '0;
    rst_ni     = 1'b0;
    hold_req   = 1'b0;
    burst_left = 0;
    calm       = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // gray levels on both sides of every boundary, plus the extremes
    directed.push_back(pixel_of(8'd0, 8'd0, 8'd0, 8'd0, 1'b0));
    directed.push_back(pixel_of(8'd42, 8'd42, 8'd42, 8'd255, 1'b0));
    directed.push_back(pixel_of(8'd43, 8'd43, 8'd43, 8'd1, 1'b0));
    directed.push_back(pixel_of(8'd84, 8'd84, 8'd84, 8'd128, 1'b0));
    directed.push_back(pixel_of(8'd85, 8'd85, 8'd85, 8'd127, 1'b1));
    directed.push_back(pixel_of(8'd127, 8'd127, 8'd127, 8'd0, 1'b0));
    directed.push_back(pixel_of(8'd128, 8'd128, 8'd128, 8'd255, 1'b0));
    directed.push_back(pixel_of(8'd169, 8'd169, 8'd169, 8'd85, 1'b0));
    directed.push_back(pixel_of(8'd170, 8'd170, 8'd170, 8'd170, 1'b1));
    directed.push_back(pixel_of(8'd212, 8'd212, 8'd212, 8'd0, 1'b0));
    directed.push_back(pixel_of(8'd213, 8'd213, 8'd213, 8'd255, 1'b0));
    directed.push_back(pixel_of(8'd255, 8'd255, 8'd255, 8'd255, 1'b1));
    // single channels at full scale, plus red and blue together
    directed.push_back(pixel_of(8'd255, 8'd0, 8'd0, 8'd0, 1'b0));
    directed.push_back(pixel_of(8'd0, 8'd255, 8'd0, 8'd255, 1'b0));
    directed.push_back(pixel_of(8'd0, 8'd0, 8'd255, 8'd0, 1'b1));
    directed.push_back(pixel_of(8'd255, 8'd0, 8'd255, 8'd170, 1'b0));
    foreach (directed[i]) send_pixel(directed[i], 1'b0);

    for (int unsigned i = 0; i < RandomPixels; i++) begin
      if ($urandom_range(0, 49) == 0) calm = ~calm;
      // long receiver hold-off while the sender keeps offering
      if (i == 600) begin
        hold_req   = 1'b1;
        burst_left = 80;
      end
      // sender pauses until the pipeline is empty
      if (i == 1200) wait_drained();
      if (burst_left > 0) begin
        burst_left--;
        send_pixel(random_pixel(), 1'b1);
      end else begin
        send_pixel(random_pixel(), calm);
      end
    end

    wait_drained();
    repeat (20) @(posedge clk_i);
    if (error_count == 0 && pending == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

FILE: sim.f
sv/tfcm_pkg.sv
sv/thermal_false_color_map.sv
sv/tfcm_checker.sv
sim/thermal_map_monitor.sv
sim/testbench.sv
